[rtl/nbec_pkg.sv]
`timescale 1ns / 1ps
package nbec_pkg;

	localparam int EXP_W = 13;
	localparam logic [10:0] EXP_MAX = 11'h7FF;
	localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;

	typedef logic signed [EXP_W-1:0] exp_t;

	typedef enum logic [1:0] {
		FOP_ADD,
		FOP_MUL,
		FOP_DIV,
		FOP_SQRT
	} fop_t;

	typedef enum logic [1:0] {
		CFG_OFFSET = 2'd0,
		CFG_SLOPE  = 2'd1,
		CFG_SCALE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_NORM,
		F_MUL,
		F_MULN,
		F_DIV,
		F_SQRT,
		F_ADDN,
		F_PACK,
		F_DONE
	} fst_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SUB,
		ST_SQRT,
		ST_MUL2,
		ST_DIV,
		ST_WAIT,
		ST_UPD,
		ST_FIN
	} st_t;

	typedef enum logic [1:0] {
		ISS_NONE,
		ISS_FPU,
		ISS_VAL,
		ISS_SKIP
	} iss_kind_t;

	typedef struct packed {
		logic        start;
		fop_t        op;
		logic [63:0] opa;
		logic [63:0] opb;
	} fpu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} fpu_rsp_t;

	typedef struct packed {
		iss_kind_t   kind;
		fop_t        op;
		logic [63:0] opa;
		logic [63:0] opb;
		logic [63:0] val;
		st_t         nxt;
	} iss_t;

	function automatic logic is_nan(input logic [63:0] v);
		return (v[62:52] == EXP_MAX) && (v[51:0] != '0);
	endfunction

	function automatic logic is_inf(input logic [63:0] v);
		return (v[62:52] == EXP_MAX) && (v[51:0] == '0);
	endfunction

	function automatic logic is_zero(input logic [63:0] v);
		return v[62:0] == '0;
	endfunction

	function automatic logic is_pos(input logic [63:0] v);
		return !v[63] && !is_zero(v) && !is_nan(v);
	endfunction

endpackage

[rtl/nbec_fpu.sv]
`timescale 1ns / 1ps
module nbec_fpu (
	input  logic              clk,
	input  logic              arst_n,
	input  nbec_pkg::fpu_req_t req,
	output nbec_pkg::fpu_rsp_t rsp
);
	import nbec_pkg::*;

	typedef struct packed {
		logic        s;
		exp_t        e;
		logic [52:0] m;
	} unp_t;

	function automatic unp_t fp_unpack(input logic [63:0] v);
		unp_t u;
		u.s = v[63];
		u.m = {v[62:52] != '0, v[51:0]};
		u.e = (v[62:52] == '0) ? exp_t'(-1022) :
			exp_t'({2'b00, v[62:52]}) - exp_t'(1023);
		return u;
	endfunction

	// sig holds 53 significant bits, a guard bit and a sticky bit; its value is
	// sig / 2^54 * 2^e. Rounds to nearest even, with gradual underflow.
	function automatic logic [63:0] fp_pack(input logic s, input exp_t e,
			input logic [54:0] sig);
		exp_t        be;
		exp_t        sh;
		logic [54:0] sh_sig;
		logic [54:0] mask;
		logic        lost;
		logic        up;
		logic [53:0] m;
		logic [63:0] res;
		be = e + exp_t'(1023);
		sh_sig = sig;
		mask = '0;
		lost = 1'b0;
		if (be > exp_t'(0)) begin
			up = sig[1] & (sig[0] | sig[2]);
			m = {1'b0, sig[54:2]} + 54'(up);
			if (m[53]) begin
				m = m >> 1;
				be = be + exp_t'(1);
			end
			if (be >= exp_t'(2047)) begin
				res = {s, INF_BITS[62:0]};
			end else begin
				res = {s, be[10:0], m[51:0]};
			end
		end else begin
			sh = exp_t'(1) - be;
			if (sh > exp_t'(54)) begin
				sh_sig = '0;
				lost = |sig;
			end else begin
				mask = (55'd1 << sh[5:0]) - 55'd1;
				lost = |(sig & mask);
				sh_sig = sig >> sh[5:0];
			end
			sh_sig[0] = sh_sig[0] | lost;
			up = sh_sig[1] & (sh_sig[0] | sh_sig[2]);
			m = {1'b0, sh_sig[54:2]} + 54'(up);
			res = {s, 10'b0, m[52], m[51:0]};
		end
		return res;
	endfunction

	fst_t         fst_q, fst_d;
	fop_t         op_q;
	logic         sa_q, sb_q, s_q;
	exp_t         ea_q, eb_q, e_q;
	logic [52:0]  ma_q, mb_q;
	logic [107:0] acc_q;
	logic [57:0]  rem_q;
	logic [53:0]  quo_q;
	logic [5:0]   cnt_q;
	logic [54:0]  sig_q;
	logic [63:0]  res_q;

	unp_t         ua, ub;
	logic         norm_done;
	logic         a_ge;
	logic [52:0]  big_m, sml_m;
	exp_t         big_e, sml_e, dexp;
	logic         big_s;
	logic [55:0]  sml_x, aligned, amask;
	logic [56:0]  big_x, sum_x, acc57;
	logic [105:0] mul_next;
	logic         div_ge;
	logic [54:0]  div_rem, div_rem_nx;
	logic [53:0]  div_q_nx;
	logic [57:0]  sq_r, sq_t, sq_r_nx;
	logic         sq_ge;
	logic [53:0]  sq_q_nx;

	assign ua = fp_unpack(req.opa);
	assign ub = fp_unpack(req.opb);
	assign norm_done = ma_q[52] && mb_q[52];
	assign acc57 = acc_q[56:0];

	always_comb begin
		a_ge = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
		big_m = a_ge ? ma_q : mb_q;
		sml_m = a_ge ? mb_q : ma_q;
		big_e = a_ge ? ea_q : eb_q;
		sml_e = a_ge ? eb_q : ea_q;
		big_s = a_ge ? sa_q : sb_q;
		dexp = big_e - sml_e;
		sml_x = {sml_m, 3'b000};
		amask = '0;
		if (dexp > exp_t'(55)) begin
			aligned = 56'd1;
		end else begin
			amask = (56'd1 << dexp[5:0]) - 56'd1;
			aligned = sml_x >> dexp[5:0];
			aligned[0] = aligned[0] | (|(sml_x & amask));
		end
		big_x = {1'b0, big_m, 3'b000};
		sum_x = (sa_q ^ sb_q) ? big_x - {1'b0, aligned} : big_x + {1'b0, aligned};

		mul_next = {acc_q[104:0], 1'b0} + (ma_q[52] ? {53'd0, mb_q} : 106'd0);

		div_ge = rem_q[54:0] >= {2'b00, mb_q};
		div_rem = div_ge ? rem_q[54:0] - {2'b00, mb_q} : rem_q[54:0];
		div_rem_nx = {div_rem[53:0], 1'b0};
		div_q_nx = {quo_q[52:0], div_ge};

		// One root bit per cycle from the next two radicand bits.
		sq_r = {rem_q[55:0], acc_q[107:106]};
		sq_t = {2'b00, quo_q, 2'b01};
		sq_ge = sq_r >= sq_t;
		sq_r_nx = sq_ge ? sq_r - sq_t : sq_r;
		sq_q_nx = {quo_q[52:0], sq_ge};
	end

	always_comb begin
		fst_d = fst_q;
		unique case (fst_q)
			F_IDLE: if (req.start) fst_d = F_NORM;
			F_NORM: begin
				if (norm_done) begin
					unique case (op_q)
						FOP_MUL: fst_d = F_MUL;
						FOP_DIV: fst_d = F_DIV;
						FOP_SQRT: fst_d = F_SQRT;
						default: fst_d = F_ADDN;
					endcase
				end
			end
			F_MUL: if (cnt_q == '0) fst_d = F_MULN;
			F_MULN: fst_d = F_PACK;
			F_DIV: if (cnt_q == '0) fst_d = F_PACK;
			F_SQRT: if (cnt_q == '0) fst_d = F_PACK;
			F_ADDN: begin
				if (acc57 == '0) begin
					fst_d = F_DONE;
				end else if (acc57[55] && !acc57[56]) begin
					fst_d = F_PACK;
				end
			end
			F_PACK: fst_d = F_DONE;
			F_DONE: fst_d = F_IDLE;
			default: fst_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			fst_q <= fst_d;
		end
	end

	always_ff @(posedge clk) begin
		case (fst_q)
			F_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					sa_q <= ua.s;
					ea_q <= ua.e;
					ma_q <= ua.m;
					sb_q <= ub.s;
					eb_q <= ub.e;
					mb_q <= ub.m;
				end
			end
			F_NORM: begin
				if (!norm_done) begin
					// Subnormal operands are brought to a leading one bit by bit.
					if (!ma_q[52]) begin
						ma_q <= {ma_q[51:0], 1'b0};
						ea_q <= ea_q - exp_t'(1);
					end
					if (!mb_q[52]) begin
						mb_q <= {mb_q[51:0], 1'b0};
						eb_q <= eb_q - exp_t'(1);
					end
				end else begin
					case (op_q)
						FOP_MUL: begin
							acc_q <= '0;
							cnt_q <= 6'd52;
							e_q <= ea_q + eb_q;
							s_q <= sa_q ^ sb_q;
						end
						FOP_DIV: begin
							quo_q <= '0;
							cnt_q <= 6'd53;
							s_q <= sa_q ^ sb_q;
							if (ma_q < mb_q) begin
								rem_q <= {4'd0, ma_q, 1'b0};
								e_q <= ea_q - eb_q - exp_t'(1);
							end else begin
								rem_q <= {5'd0, ma_q};
								e_q <= ea_q - eb_q;
							end
						end
						FOP_SQRT: begin
							quo_q <= '0;
							rem_q <= '0;
							cnt_q <= 6'd53;
							s_q <= 1'b0;
							if (ea_q[0]) begin
								acc_q <= {ma_q, 1'b0, 54'd0};
								e_q <= exp_t'(ea_q - exp_t'(1)) >>> 1;
							end else begin
								acc_q <= {1'b0, ma_q, 54'd0};
								e_q <= ea_q >>> 1;
							end
						end
						default: begin
							acc_q <= {51'd0, sum_x};
							e_q <= big_e;
							s_q <= big_s;
						end
					endcase
				end
			end
			F_MUL: begin
				acc_q <= {2'b00, mul_next};
				ma_q <= {ma_q[51:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			F_MULN: begin
				if (acc_q[105]) begin
					sig_q <= {acc_q[105:52], |acc_q[51:0]};
					e_q <= e_q + exp_t'(1);
				end else begin
					sig_q <= {acc_q[104:51], |acc_q[50:0]};
				end
			end
			F_DIV: begin
				rem_q <= {3'd0, div_rem_nx};
				quo_q <= div_q_nx;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) sig_q <= {div_q_nx, |div_rem_nx};
			end
			F_SQRT: begin
				acc_q <= {acc_q[105:0], 2'b00};
				rem_q <= sq_r_nx;
				quo_q <= sq_q_nx;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) sig_q <= {sq_q_nx, |sq_r_nx};
			end
			F_ADDN: begin
				if (acc57 == '0) begin
					// Exact cancellation gives positive zero.
					res_q <= '0;
				end else if (acc57[56]) begin
					acc_q <= {51'd0, 1'b0, acc57[56:2], acc57[1] | acc57[0]};
					e_q <= e_q + exp_t'(1);
				end else if (acc57[55]) begin
					sig_q <= {acc57[55:2], |acc57[1:0]};
				end else begin
					acc_q <= {51'd0, acc57[55:0], 1'b0};
					e_q <= e_q - exp_t'(1);
				end
			end
			F_PACK: res_q <= fp_pack(s_q, e_q, sig_q);
			default: ;
		endcase
	end

	assign rsp.busy = (fst_q != F_IDLE);
	assign rsp.done = (fst_q == F_DONE);
	assign rsp.result = res_q;

endmodule

[rtl/noise_bound_error_checker_core.sv]
`timescale 1ns / 1ps
// A pair that is skipped up front goes from acceptance through the finish state back to ready.
// An evaluated pair takes longer, and longer still with subnormal values or deep
// cancellation: one shared floating point unit does the six operations in turn,
// one bit per cycle in multiply, divide and square root, one bit per cycle when normalizing.
// One pair is in work at a time. Reset clears the registers and the running maximum to +0.0.
module noise_bound_error_checker_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // sample_value[63:0], decoded_value[127:64]
	input  logic         s_tlast,  // last_sample
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // worst_ratio[63:0]
	output logic         m_tuser,  // bad_setup
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import nbec_pkg::*;

	st_t         st_q, st_d, ret_q;
	logic [63:0] off_q, slope_q, scale_q;
	logic [63:0] worst_q;
	logic [63:0] x_q, y_q, v_q, num_q, val_q;
	logic        last_q, bad_q;
	logic        ovalid_q, obad_q;
	logic [63:0] odata_q;

	logic [63:0] in_x, in_y, a_eff;
	logic        in_bad, in_equal, item_live, out_free;
	iss_t        iss;
	fpu_req_t    fpu_req;
	fpu_rsp_t    fpu_rsp;

	assign in_x = s_tdata[63:0];
	assign in_y = s_tdata[127:64];
	assign in_bad = !is_pos(scale_q) || !is_pos(slope_q);
	assign in_equal = !is_nan(in_y) &&
		((in_x == in_y) || (is_zero(in_x) && is_zero(in_y)));
	assign item_live = !in_bad && (in_x[62:52] != EXP_MAX) && !in_equal;
	// A negative offset is used as zero; NaN and negative zero pass unchanged.
	assign a_eff = (off_q[63] && !is_nan(off_q) && !is_zero(off_q)) ? 64'd0 : off_q;
	assign out_free = !ovalid_q || m_tready;

	// Special operands are settled here; the shared unit sees finite nonzero values only.
	always_comb begin
		iss.kind = ISS_NONE;
		iss.op = FOP_ADD;
		iss.opa = '0;
		iss.opb = '0;
		iss.val = '0;
		iss.nxt = ST_FIN;
		unique case (st_q) inside
			ST_MUL: begin
				iss.nxt = ST_ADD;
				if (is_inf(slope_q)) begin
					iss.kind = is_zero(x_q) ? ISS_SKIP : ISS_VAL;
					iss.val = {x_q[63], INF_BITS[62:0]};
				end else if (is_zero(x_q)) begin
					iss.kind = ISS_VAL;
					iss.val = x_q;
				end else begin
					iss.kind = ISS_FPU;
					iss.op = FOP_MUL;
					iss.opa = slope_q;
					iss.opb = x_q;
				end
			end
			ST_ADD: begin
				iss.nxt = ST_SUB;
				iss.kind = ISS_VAL;
				if (is_nan(a_eff)) begin
					iss.kind = ISS_SKIP;
				end else if (is_inf(a_eff)) begin
					iss.kind = (is_inf(val_q) && val_q[63]) ? ISS_SKIP : ISS_VAL;
					iss.val = INF_BITS;
				end else if (is_inf(val_q) || is_zero(a_eff)) begin
					iss.val = val_q;
				end else if (is_zero(val_q)) begin
					iss.val = a_eff;
				end else begin
					iss.kind = ISS_FPU;
					iss.op = FOP_ADD;
					iss.opa = a_eff;
					iss.opb = val_q;
				end
			end
			ST_SUB: begin
				iss.nxt = ST_SQRT;
				iss.kind = ISS_VAL;
				if (!is_pos(val_q) || is_nan(y_q)) begin
					iss.kind = ISS_SKIP;
				end else if (is_inf(y_q)) begin
					iss.val = INF_BITS;
				end else if (is_zero(x_q)) begin
					iss.val = y_q;
				end else if (is_zero(y_q)) begin
					iss.val = x_q;
				end else begin
					iss.kind = ISS_FPU;
					iss.op = FOP_ADD;
					iss.opa = x_q;
					iss.opb = {~y_q[63], y_q[62:0]};
				end
			end
			ST_SQRT: begin
				iss.nxt = ST_MUL2;
				if (is_inf(v_q)) begin
					iss.kind = ISS_VAL;
					iss.val = INF_BITS;
				end else begin
					iss.kind = ISS_FPU;
					iss.op = FOP_SQRT;
					iss.opa = v_q;
					iss.opb = v_q;
				end
			end
			ST_MUL2: begin
				iss.nxt = ST_DIV;
				if (is_inf(scale_q) || is_inf(val_q)) begin
					iss.kind = ISS_VAL;
					iss.val = INF_BITS;
				end else begin
					iss.kind = ISS_FPU;
					iss.op = FOP_MUL;
					iss.opa = scale_q;
					iss.opb = val_q;
				end
			end
			ST_DIV: begin
				iss.nxt = ST_UPD;
				iss.kind = ISS_VAL;
				if (is_zero(val_q)) begin
					iss.val = INF_BITS;
				end else if (is_inf(val_q)) begin
					// An infinite bound gives zero; the pair is skipped when the error is infinite too.
					iss.kind = is_inf(num_q) ? ISS_SKIP : ISS_VAL;
					iss.val = '0;
				end else if (is_inf(num_q)) begin
					iss.val = INF_BITS;
				end else begin
					iss.kind = ISS_FPU;
					iss.op = FOP_DIV;
					iss.opa = num_q;
					iss.opb = val_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q) inside
			ST_IDLE: if (s_tvalid) st_d = item_live ? ST_MUL : ST_FIN;
			ST_MUL, ST_ADD, ST_SUB, ST_SQRT, ST_MUL2, ST_DIV: begin
				case (iss.kind)
					ISS_FPU: st_d = ST_WAIT;
					ISS_VAL: st_d = iss.nxt;
					default: st_d = ST_FIN;
				endcase
			end
			ST_WAIT: if (fpu_rsp.done) st_d = ret_q;
			ST_UPD: st_d = ST_FIN;
			ST_FIN: if (!last_q || out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == ST_IDLE);
		fpu_req.start = (iss.kind == ISS_FPU);
		fpu_req.op = iss.op;
		fpu_req.opa = iss.opa;
		fpu_req.opb = iss.opb;
	end

	nbec_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			off_q <= '0;
			slope_q <= '0;
			scale_q <= '0;
			worst_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OFFSET: off_q <= cfg_data;
					CFG_SLOPE: slope_q <= cfg_data;
					CFG_SCALE: scale_q <= cfg_data;
					default: ;
				endcase
			end
			if (iss.kind == ISS_FPU) ret_q <= iss.nxt;
			// Both values are non-negative and not NaN, so the bit patterns order them.
			if ((st_q == ST_UPD) && (val_q > worst_q)) worst_q <= val_q;
			if ((st_q == ST_FIN) && last_q && out_free) begin
				ovalid_q <= 1'b1;
				worst_q <= '0;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_q <= in_x;
			y_q <= in_y;
			last_q <= s_tlast;
			bad_q <= in_bad;
		end
		if (iss.kind == ISS_VAL) val_q <= iss.val;
		if ((st_q == ST_WAIT) && fpu_rsp.done) val_q <= fpu_rsp.result;
		if (st_q == ST_SUB) v_q <= val_q;
		if (st_q == ST_SQRT) num_q <= {1'b0, val_q[62:0]};
		if ((st_q == ST_FIN) && last_q && out_free) begin
			odata_q <= bad_q ? 64'd0 : worst_q;
			obad_q <= bad_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = odata_q;
	assign m_tuser = obad_q;

	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !fpu_rsp.busy)
		else $error("input ready while the arithmetic unit is busy");

	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
		else $error("bad setup result carries a nonzero ratio");

	a_worst_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!worst_q[63])
		else $error("running maximum became negative");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> (st_q == ST_WAIT))
		else $error("arithmetic result arrived outside the wait state");

endmodule

[test/tb_noise_bound_error_checker_core.sv]
`timescale 1ns / 1ps
module tb_noise_bound_error_checker_core;
	import nbec_pkg::*;

	typedef struct {
		logic [63:0] xb;
		logic [63:0] yb;
		logic        last;
	} pair_t;

	typedef struct {
		logic [63:0] worst;
		logic        bad;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tuser;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = CFG_OFFSET;
	logic [63:0]  cfg_data = '0;

	noise_bound_error_checker_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mirror of the block's registers and running maximum.
	logic [63:0] offset_bits = '0;
	logic [63:0] slope_bits = '0;
	logic [63:0] scale_bits = '0;
	logic [63:0] run_max = '0;

	pair_t    pending_pairs[$];
	verdict_t worst_q[$];
	int       errors = 0;
	int       pairs_taken = 0;
	int       pairs_scored = 0;
	int       verdicts_seen = 0;
	int       bad_verdicts = 0;
	bit       long_hold_go = 1'b0;

	function automatic void score_pair(input logic [63:0] xb, input logic [63:0] yb,
			input logic last);
		real a, b, k, x, y, v, num, den, ratio;
		logic [63:0] diff;
		logic bad, have;
		verdict_t vd;
		a = $bitstoreal(offset_bits);
		b = $bitstoreal(slope_bits);
		k = $bitstoreal(scale_bits);
		bad = !(k > 0.0) || !(b > 0.0);
		if (!bad && xb[62:52] != EXP_MAX) begin
			x = $bitstoreal(xb);
			y = $bitstoreal(yb);
			if (!(x == y)) begin
				if (a < 0.0)
					a = 0.0;
				v = a + b * x;
				if (v > 0.0) begin
					pairs_scored++;
					diff = $realtobits(x - y);
					num = $bitstoreal({1'b0, diff[62:0]});
					den = k * $sqrt(v);
					have = 1'b1;
					ratio = 0.0;
					if (den == 0.0) begin
						// A bound that rounds to zero makes any real error infinite.
						if (num > 0.0)
							ratio = $bitstoreal(INF_BITS);
						else
							have = 1'b0;
					end else begin
						ratio = num / den;
					end
					if (have && ratio > $bitstoreal(run_max))
						run_max = $realtobits(ratio);
				end
			end
		end
		if (last) begin
			vd.bad = bad;
			vd.worst = bad ? 64'h0 : run_max;
			worst_q.push_back(vd);
			run_max = '0;
		end
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 8;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		pair_t p;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pairs_taken++;
				score_pair(s_tdata[63:0], s_tdata[127:64], s_tlast);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					p = pending_pairs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {p.yb, p.xb};
					s_tlast <= p.last;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall mode is redrawn at random, periodically; one long hold on request.
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (long_hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((rx_cycle / 5) % 2 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		verdict_t vd;
		if (arst_n && m_tvalid && m_tready) begin
			verdicts_seen++;
			if (m_tuser)
				bad_verdicts++;
			if (worst_q.size() == 0) begin
				$error("unexpected result worst_ratio=%h bad_setup=%b", m_tdata, m_tuser);
				errors++;
			end else begin
				vd = worst_q.pop_front();
				if (m_tdata !== vd.worst) begin
					$error("worst_ratio expected %h actual %h", vd.worst, m_tdata);
					errors++;
				end
				if (m_tuser !== vd.bad) begin
					$error("bad_setup expected %b actual %b", vd.bad, m_tuser);
					errors++;
				end
			end
		end
	end

	function automatic logic [63:0] rand_bits();
		return {$urandom(), $urandom()};
	endfunction

	function automatic pair_t make_pair(input logic [63:0] xb, input logic [63:0] yb,
			input logic last);
		pair_t p;
		p.xb = xb;
		p.yb = yb;
		p.last = last;
		return p;
	endfunction

	// Mostly plausible sample/reconstruction pairs, with a share of odd values.
	function automatic pair_t random_pair(input logic last);
		real x, err;
		logic [63:0] xb, yb;
		int pick;
		pick = $urandom_range(0, 99);
		x = real'($urandom_range(0, 200000)) / 37.0 - 100.0;
		err = (real'($urandom_range(0, 20000)) - 10000.0) / real'($urandom_range(1, 5000));
		xb = $realtobits(x);
		yb = $realtobits(x + err);
		if (pick < 8) begin
			xb = rand_bits();
			yb = rand_bits();
		end else if (pick < 14) begin
			yb = xb;
		end else if (pick < 18) begin
			xb = {rand_bits() & 64'h800F_FFFF_FFFF_FFFF} | 64'h7FF0_0000_0000_0000;
		end else if (pick < 22) begin
			yb = rand_bits() | 64'h7FF0_0000_0000_0000;
		end else if (pick < 26) begin
			xb = rand_bits() & 64'h000F_FFFF_FFFF_FFFF;
			yb = rand_bits() & 64'h800F_FFFF_FFFF_FFFF;
		end else if (pick < 30) begin
			xb = (rand_bits() & 64'h000F_FFFF_FFFF_FFFF) | 64'h7FE0_0000_0000_0000;
			yb = {xb[63:40], ~xb[39:0]};
		end
		return make_pair(xb, yb, last);
	endfunction

	task automatic queue_runs(input int count);
		int left, len;
		left = count;
		while (left > 0) begin
			len = $urandom_range(1, 16);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				pending_pairs.push_back(random_pair(i == len - 1));
			left -= len;
		end
	endtask

	task automatic wait_idle();
		wait (pending_pairs.size() == 0 && !s_tvalid && worst_q.size() == 0);
		repeat (1000) @(posedge clk);
	endtask

	task automatic set_curve(input logic [63:0] off, input logic [63:0] slp,
			input logic [63:0] scl);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OFFSET;
		cfg_data <= off;
		@(posedge clk);
		cfg_index <= CFG_SLOPE;
		cfg_data <= slp;
		@(posedge clk);
		cfg_index <= CFG_SCALE;
		cfg_data <= scl;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_bits = off;
		slope_bits = slp;
		scale_bits = scl;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers still at reset: every run reports a bad setup.
		pending_pairs.push_back(make_pair($realtobits(1.0), $realtobits(2.0), 1'b0));
		pending_pairs.push_back(make_pair($realtobits(5.0), $realtobits(4.0), 1'b1));
		pending_pairs.push_back(make_pair(64'h0, 64'h0, 1'b1));
		wait_idle();

		set_curve($realtobits(1.0), $realtobits(0.5), $realtobits(3.0));
		pending_pairs.push_back(make_pair(64'h0, 64'h0, 1'b1));
		pending_pairs.push_back(make_pair($realtobits(10.0), $realtobits(10.0), 1'b0));
		pending_pairs.push_back(make_pair(64'h7FF8_0000_0000_0001, 64'h0, 1'b0));
		pending_pairs.push_back(make_pair(INF_BITS, 64'h0, 1'b0));
		pending_pairs.push_back(make_pair(64'hFFF0_0000_0000_0000, 64'h0, 1'b1));
		pending_pairs.push_back(make_pair($realtobits(4.0), $realtobits(4.5), 1'b0));
		pending_pairs.push_back(make_pair($realtobits(4.0), 64'h7FF8_0000_0000_0000, 1'b1));
		pending_pairs.push_back(make_pair($realtobits(-10.0), $realtobits(-9.0), 1'b1));
		pending_pairs.push_back(make_pair(64'h0, 64'h8000_0000_0000_0000, 1'b0));
		pending_pairs.push_back(make_pair(64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
			1'b0));
		pending_pairs.push_back(make_pair($realtobits(2.0), INF_BITS, 1'b0));
		pending_pairs.push_back(make_pair($realtobits(3.0), $realtobits(1.0), 1'b1));
		pending_pairs.push_back(make_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
			1'b1));
		pending_pairs.push_back(make_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1));
		queue_runs(300);
		// Hold the result side for a long stretch while pairs keep coming.
		long_hold_go = 1'b1;
		wait_idle();

		// A negative offset counts as zero; a tiny scale pushes ratios high.
		set_curve($realtobits(-2.0), $realtobits(1.0e-3), $realtobits(1.0e-300));
		queue_runs(250);
		wait_idle();

		// NaN offset: nothing is ever scored.
		set_curve(64'h7FF8_0000_0000_0000, $realtobits(1.0), $realtobits(1.0));
		queue_runs(60);
		wait_idle();

		// Smallest subnormals everywhere: the bound underflows to zero.
		set_curve(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001);
		queue_runs(200);
		wait_idle();

		set_curve(64'h7FEF_FFFF_FFFF_FFFF, INF_BITS, INF_BITS);
		queue_runs(150);
		wait_idle();

		set_curve(64'hFFFF_FFFF_FFFF_FFFF, $realtobits(-1.0), $realtobits(2.0));
		queue_runs(60);
		wait_idle();

		set_curve(64'h0, $realtobits(2.0), 64'hFFFF_FFFF_FFFF_FFFF);
		queue_runs(60);
		wait_idle();

		set_curve($realtobits(0.25), $realtobits(1.5), $realtobits(0.5));
		queue_runs(450);
		wait_idle();

		$display("Scored %0d of %0d pairs across nine register settings;", pairs_scored,
			pairs_taken);
		$display("checked %0d results, %0d of them with a bad setup.", verdicts_seen,
			bad_verdicts);
		if (errors == 0)
			$display("noise_bound_error_checker_core verification clean");
		else
			$display("noise_bound_error_checker_core verification failed");
		$finish;
	end

	initial begin
		#60ms;
		$display("noise_bound_error_checker_core verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/nbec_pkg.sv
rtl/nbec_fpu.sv
rtl/noise_bound_error_checker_core.sv
test/tb_noise_bound_error_checker_core.sv
